@@ hw/rtl/hyperbolic_radon_nearest_core_assert.svh @@
// Assertion macros used by the back end of the hyperbolic Radon core
`ifndef HYPERBOLIC_RADON_NEAREST_CORE_ASSERT_SVH
`define HYPERBOLIC_RADON_NEAREST_CORE_ASSERT_SVH

// same-cycle implication
`define HRN_ASSERT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("hrn assertion failed");

// next-cycle implication
`define HRN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("hrn assertion failed");

`endif

@@ hw/rtl/hrn_pkg.sv @@
// Types, codes and helpers of the hyperbolic Radon core
package hrn_pkg;

   localparam int NT_W   = 14;
   localparam int NTR_W  = 10;
   localparam int LW     = NT_W + NTR_W;
   localparam int DIVN_W = 80;
   localparam int DIVD_W = 33;
   localparam int QDEPTH = 2;

   localparam logic [2:0] OP_LOAD_TIME   = 3'd0;
   localparam logic [2:0] OP_LOAD_OFFSET = 3'd1;
   localparam logic [2:0] OP_LOAD_SLOW   = 3'd2;
   localparam logic [2:0] OP_LOAD_SOURCE = 3'd3;
   localparam logic [2:0] OP_RUN         = 3'd4;
   localparam logic [2:0] OP_READ        = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   localparam logic [1:0] CSR_ADJOINT = 2'd0;
   localparam logic [1:0] CSR_TIME    = 2'd1;
   localparam logic [1:0] CSR_OFFSET  = 2'd2;
   localparam logic [1:0] CSR_CURVE   = 2'd3;

   typedef enum logic [2:0] {
      K_NONE, K_TIME, K_OFFSET, K_SLOW, K_SOURCE, K_RUN, K_READ, K_RANGE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] index;
      logic [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic             adjoint;
      logic [NT_W-1:0]  nt;
      logic [NTR_W-1:0] nh;
      logic [NTR_W-1:0] nq;
   } cfg_type;

   typedef enum logic [4:0] {
      BS_IDLE, BS_READ, BS_CLEAR, BS_DT0, BS_DT1, BS_DT2, BS_FETCH, BS_OPER,
      BS_SQUARE, BS_DIVS, BS_DIV1, BS_ROOT, BS_DIVS2, BS_DIV2, BS_PLACE,
      BS_ACC_RD, BS_ACC_WR, BS_NEXT, BS_DONE
   } back_state_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

@@ hw/rtl/hrn_if.sv @@
// Request and response channel interfaces of the hyperbolic Radon core
interface hrn_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [15:0]        index;
   logic signed [31:0] load_value;
   modport source (output valid, opcode, index, load_value, input ready);
   modport sink (input valid, opcode, index, load_value, output ready);
endinterface

interface hrn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] read_value;
   logic [1:0]         status;
   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

@@ hw/rtl/hrn_front.sv @@
// Front end: configuration registers, request intake and bounds classification
module hrn_front #(
   parameter int MAX_TIMES   = 1024,
   parameter int MAX_OFFSETS = 64,
   parameter int MAX_CURVES  = 64
) (
   input  logic              clock,
   input  logic              reset,
   hrn_req_if.sink           req_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [10:0]       csr_wdata,
   input  logic              q_full,
   output logic              q_push,
   output hrn_pkg::cmd_type  q_cmd,
   output hrn_pkg::cfg_type  cfg
);

   logic        adjoint_ff, adjoint_in;
   logic [10:0] time_count_ff, time_count_in;
   logic [6:0]  offset_count_ff, offset_count_in;
   logic [6:0]  curve_count_ff, curve_count_in;

   logic [hrn_pkg::NT_W-1:0]  nt;
   logic [hrn_pkg::NTR_W-1:0] nh, nq;
   logic [hrn_pkg::LW-1:0]    idx, qt_len, ht_len, src_len, res_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         adjoint_ff      <= 1'b0;
         time_count_ff   <= 11'd1024;
         offset_count_ff <= 7'd64;
         curve_count_ff  <= 7'd64;
      end else begin
         adjoint_ff      <= adjoint_in;
         time_count_ff   <= time_count_in;
         offset_count_ff <= offset_count_in;
         curve_count_ff  <= curve_count_in;
      end
   end

   always_comb begin
      adjoint_in      = adjoint_ff;
      time_count_in   = time_count_ff;
      offset_count_in = offset_count_ff;
      curve_count_in  = curve_count_ff;
      if (csr_we) begin
         case (csr_index)
            hrn_pkg::CSR_ADJOINT: adjoint_in      = csr_wdata[0];
            hrn_pkg::CSR_TIME:    time_count_in   = csr_wdata;
            hrn_pkg::CSR_OFFSET:  offset_count_in = csr_wdata[6:0];
            hrn_pkg::CSR_CURVE:   curve_count_in  = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (time_count_ff < 11'd2) nt = hrn_pkg::NT_W'(2);
      else if (32'(time_count_ff) > 32'(MAX_TIMES)) nt = hrn_pkg::NT_W'(MAX_TIMES);
      else nt = hrn_pkg::NT_W'(time_count_ff);
      if (offset_count_ff == 7'd0) nh = hrn_pkg::NTR_W'(1);
      else if (32'(offset_count_ff) > 32'(MAX_OFFSETS)) nh = hrn_pkg::NTR_W'(MAX_OFFSETS);
      else nh = hrn_pkg::NTR_W'(offset_count_ff);
      if (curve_count_ff == 7'd0) nq = hrn_pkg::NTR_W'(1);
      else if (32'(curve_count_ff) > 32'(MAX_CURVES)) nq = hrn_pkg::NTR_W'(MAX_CURVES);
      else nq = hrn_pkg::NTR_W'(curve_count_ff);
   end

   assign qt_len  = hrn_pkg::LW'(nq) * hrn_pkg::LW'(nt);
   assign ht_len  = hrn_pkg::LW'(nh) * hrn_pkg::LW'(nt);
   assign src_len = adjoint_ff ? ht_len : qt_len;
   assign res_len = adjoint_ff ? qt_len : ht_len;
   assign idx     = hrn_pkg::LW'(req_chan.index);

   always_comb begin
      q_cmd.index = req_chan.index;
      q_cmd.value = req_chan.load_value;
      case (req_chan.opcode)
         hrn_pkg::OP_LOAD_TIME:
            q_cmd.kind = (idx < hrn_pkg::LW'(nt)) ? hrn_pkg::K_TIME : hrn_pkg::K_RANGE;
         hrn_pkg::OP_LOAD_OFFSET:
            q_cmd.kind = (idx < hrn_pkg::LW'(nh)) ? hrn_pkg::K_OFFSET : hrn_pkg::K_RANGE;
         hrn_pkg::OP_LOAD_SLOW:
            q_cmd.kind = (idx < qt_len) ? hrn_pkg::K_SLOW : hrn_pkg::K_RANGE;
         hrn_pkg::OP_LOAD_SOURCE:
            q_cmd.kind = (idx < src_len) ? hrn_pkg::K_SOURCE : hrn_pkg::K_RANGE;
         hrn_pkg::OP_RUN:
            q_cmd.kind = hrn_pkg::K_RUN;
         hrn_pkg::OP_READ:
            q_cmd.kind = (idx < res_len) ? hrn_pkg::K_READ : hrn_pkg::K_RANGE;
         default:
            q_cmd.kind = hrn_pkg::K_NONE;
      endcase
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   assign cfg.adjoint = adjoint_ff;
   assign cfg.nt      = nt;
   assign cfg.nh      = nh;
   assign cfg.nq      = nq;

endmodule

@@ hw/rtl/hrn_queue.sv @@
// Two-entry command queue between front and back ends
module hrn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hrn_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output hrn_pkg::cmd_type pop_cmd,
   output logic             empty
);

   hrn_pkg::cmd_type entry_ff [hrn_pkg::QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full    = (count_ff == 2'(hrn_pkg::QDEPTH));
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/hrn_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle
module hrn_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hrn_pkg::DIVN_W-1:0] dividend,
   input  logic [hrn_pkg::DIVD_W-1:0] divisor,
   output logic                       busy,
   output logic [hrn_pkg::DIVN_W-1:0] quotient
);

   localparam int CW = $clog2(hrn_pkg::DIVN_W + 1);

   logic                       busy_ff, busy_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [hrn_pkg::DIVN_W-1:0] num_ff, num_in;
   logic [hrn_pkg::DIVD_W-1:0] rem_ff, rem_in;
   logic [hrn_pkg::DIVD_W-1:0] den_ff, den_in;
   logic [hrn_pkg::DIVD_W:0]   shifted;
   logic [hrn_pkg::DIVD_W+1:0] diff;

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign shifted = {rem_ff, num_ff[hrn_pkg::DIVN_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(hrn_pkg::DIVN_W);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[hrn_pkg::DIVN_W-2:0], ~diff[hrn_pkg::DIVD_W+1]};
         rem_in = diff[hrn_pkg::DIVD_W+1] ? shifted[hrn_pkg::DIVD_W-1:0]
                                          : diff[hrn_pkg::DIVD_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

@@ hw/rtl/hrn_back.sv @@
// Back end: stores, operator sequencer and response register
`include "hyperbolic_radon_nearest_core_assert.svh"
module hrn_back #(
   parameter int MAX_TIMES   = 1024,
   parameter int MAX_OFFSETS = 64,
   parameter int MAX_CURVES  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  hrn_pkg::cfg_type cfg,
   input  hrn_pkg::cmd_type q_cmd,
   input  logic             q_empty,
   output logic             q_pop,
   hrn_rsp_if.source        rsp_chan
);

   localparam int TRACE_MAX = (MAX_OFFSETS > MAX_CURVES) ? MAX_OFFSETS : MAX_CURVES;
   localparam int SD        = TRACE_MAX * MAX_TIMES;
   localparam int SLD       = MAX_CURVES * MAX_TIMES;
   localparam int TAW       = $clog2(MAX_TIMES);
   localparam int OAW       = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
   localparam int SLW       = $clog2(SLD);
   localparam int SAW       = $clog2(SD);
   localparam int LW        = hrn_pkg::LW;
   localparam int NT_W      = hrn_pkg::NT_W;
   localparam int NTR_W     = hrn_pkg::NTR_W;

   logic [31:0] time_mem [MAX_TIMES];
   logic [31:0] off_mem [MAX_OFFSETS];
   logic [31:0] slow_mem [SLD];
   logic [31:0] src_mem [SD];
   logic [39:0] res_mem [SD];

   logic [31:0] time_rd, off_rd, slow_rd, src_rd;
   logic [39:0] res_rd;
   logic        time_we, off_we, slow_we, src_we, res_we;
   logic [TAW-1:0] time_ra;
   logic [OAW-1:0] off_ra;
   logic [SLW-1:0] slow_ra;
   logic [SAW-1:0] src_ra, res_ra, res_wa;
   logic [39:0]    res_wd;

   hrn_pkg::back_state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              ran_ff, ran_in;
   logic [SAW-1:0]    rd_addr_ff, rd_addr_in;
   logic [SAW-1:0]    clr_ff, clr_in;
   logic [31:0]       t0_ff, t0_in;
   logic [31:0]       dt_ff, dt_in;
   logic [NT_W-1:0]   it_ff, it_in;
   logic [NTR_W-1:0]  ih_ff, ih_in, iq_ff, iq_in;
   logic [31:0]       tm_ff, tm_in, hm_ff, hm_in;
   logic [30:0]       vs_ff, vs_in;
   logic [63:0]       t2_ff, t2_in, h2_ff, h2_in;
   logic [63:0]       x_ff, x_in, root_ff, root_in, bit_ff, bit_in;
   logic [NT_W-1:0]   idx_ff, idx_in;
   logic [LW-1:0]     dst_ff, dst_in, src_ff, src_in;

   logic                       div_start, div_busy;
   logic [hrn_pkg::DIVN_W-1:0] div_dividend, div_q;
   logic [hrn_pkg::DIVD_W-1:0] div_divisor;

   logic           out_free;
   logic [LW-1:0]  slow_addr;
   logic [33:0]    dts;
   logic [64:0]    rad_sum, trial;
   logic [NTR_W-1:0] row_d, row_s;
   logic [NT_W-1:0]  col_d, col_s;

   hrn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (time_we) time_mem[TAW'(q_cmd.index)] <= q_cmd.value;
      time_rd <= time_mem[time_ra];
      if (off_we) off_mem[OAW'(q_cmd.index)] <= q_cmd.value;
      off_rd <= off_mem[off_ra];
      if (slow_we) slow_mem[SLW'(q_cmd.index)] <= q_cmd.value;
      slow_rd <= slow_mem[slow_ra];
      if (src_we) src_mem[SAW'(q_cmd.index)] <= q_cmd.value;
      src_rd <= src_mem[src_ra];
      if (res_we) res_mem[res_wa] <= res_wd;
      res_rd <= res_mem[res_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrn_pkg::BS_IDLE;
         rsp_valid_ff <= 1'b0;
         ran_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ran_ff       <= ran_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rd_addr_ff    <= rd_addr_in;
      clr_ff        <= clr_in;
      t0_ff         <= t0_in;
      dt_ff         <= dt_in;
      it_ff         <= it_in;
      ih_ff         <= ih_in;
      iq_ff         <= iq_in;
      tm_ff         <= tm_in;
      hm_ff         <= hm_in;
      vs_ff         <= vs_in;
      t2_ff         <= t2_in;
      h2_ff         <= h2_in;
      x_ff          <= x_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      idx_ff        <= idx_in;
      dst_ff        <= dst_in;
      src_ff        <= src_in;
   end

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign slow_addr = LW'(iq_ff) * LW'(cfg.nt) + LW'(it_ff);
   assign dts       = {{2{time_rd[31]}}, time_rd} - {{2{t0_ff[31]}}, t0_ff};
   assign rad_sum   = {1'b0, t2_ff} + {1'b0, div_q[63:0]};
   assign trial     = {1'b0, root_ff} + {1'b0, bit_ff};
   assign row_d     = cfg.adjoint ? iq_ff : ih_ff;
   assign col_d     = cfg.adjoint ? it_ff : idx_ff;
   assign row_s     = cfg.adjoint ? ih_ff : iq_ff;
   assign col_s     = cfg.adjoint ? idx_ff : it_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ran_in        = ran_ff;
      rd_addr_in    = rd_addr_ff;
      clr_in        = clr_ff;
      t0_in         = t0_ff;
      dt_in         = dt_ff;
      it_in         = it_ff;
      ih_in         = ih_ff;
      iq_in         = iq_ff;
      tm_in         = tm_ff;
      hm_in         = hm_ff;
      vs_in         = vs_ff;
      t2_in         = t2_ff;
      h2_in         = h2_ff;
      x_in          = x_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      idx_in        = idx_ff;
      dst_in        = dst_ff;
      src_in        = src_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      time_we       = 1'b0;
      off_we        = 1'b0;
      slow_we       = 1'b0;
      src_we        = 1'b0;
      res_we        = 1'b0;
      res_wa        = SAW'(dst_ff);
      res_wd        = '0;
      time_ra       = TAW'(it_ff);
      off_ra        = OAW'(ih_ff);
      slow_ra       = SLW'(slow_addr);
      src_ra        = SAW'(src_ff);
      res_ra        = SAW'(dst_ff);

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         hrn_pkg::BS_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop         = 1'b1;
               rsp_value_in  = 32'd0;
               rsp_status_in = hrn_pkg::STAT_OK;
               case (q_cmd.kind)
                  hrn_pkg::K_TIME: begin
                     time_we      = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  hrn_pkg::K_OFFSET: begin
                     off_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  hrn_pkg::K_SLOW: begin
                     slow_we      = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  hrn_pkg::K_SOURCE: begin
                     src_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  hrn_pkg::K_RUN: begin
                     clr_in   = '0;
                     state_in = hrn_pkg::BS_CLEAR;
                  end
                  hrn_pkg::K_READ: begin
                     rd_addr_in = SAW'(q_cmd.index);
                     res_ra     = SAW'(q_cmd.index);
                     state_in   = hrn_pkg::BS_READ;
                  end
                  hrn_pkg::K_RANGE: begin
                     rsp_status_in = hrn_pkg::STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         hrn_pkg::BS_READ: begin
            res_ra = rd_addr_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hrn_pkg::STAT_OK;
               if (!ran_ff) begin
                  rsp_value_in = 32'd0;
               end else if (res_rd[39:31] == {9{res_rd[39]}}) begin
                  rsp_value_in = res_rd[31:0];
               end else begin
                  rsp_status_in = hrn_pkg::STAT_SAT;
                  rsp_value_in  = res_rd[39] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end
               state_in = hrn_pkg::BS_IDLE;
            end
         end
         hrn_pkg::BS_CLEAR: begin
            res_we = 1'b1;
            res_wa = clr_ff;
            if (clr_ff == SAW'(SD - 1)) begin
               ran_in   = 1'b1;
               state_in = hrn_pkg::BS_DT0;
            end else begin
               clr_in = clr_ff + SAW'(1);
            end
         end
         hrn_pkg::BS_DT0: begin
            time_ra  = '0;
            state_in = hrn_pkg::BS_DT1;
         end
         hrn_pkg::BS_DT1: begin
            time_ra  = TAW'(1);
            t0_in    = time_rd;
            state_in = hrn_pkg::BS_DT2;
         end
         hrn_pkg::BS_DT2: begin
            if (dts[33] || dts == 34'd0) begin
               state_in = hrn_pkg::BS_DONE;
            end else begin
               dt_in    = dts[31:0];
               it_in    = '0;
               ih_in    = '0;
               iq_in    = '0;
               state_in = hrn_pkg::BS_FETCH;
            end
         end
         hrn_pkg::BS_FETCH: begin
            state_in = hrn_pkg::BS_OPER;
         end
         hrn_pkg::BS_OPER: begin
            if (slow_rd[31] || slow_rd == 32'd0) begin
               state_in = hrn_pkg::BS_NEXT;
            end else begin
               tm_in    = hrn_pkg::mag32(time_rd);
               hm_in    = hrn_pkg::mag32(off_rd);
               vs_in    = slow_rd[30:0];
               state_in = hrn_pkg::BS_SQUARE;
            end
         end
         hrn_pkg::BS_SQUARE: begin
            t2_in    = 64'(tm_ff) * 64'(tm_ff);
            h2_in    = 64'(hm_ff) * 64'(hm_ff);
            state_in = hrn_pkg::BS_DIVS;
         end
         hrn_pkg::BS_DIVS: begin
            div_start    = 1'b1;
            div_dividend = {h2_ff, 16'h0000};
            div_divisor  = hrn_pkg::DIVD_W'(vs_ff);
            state_in     = hrn_pkg::BS_DIV1;
         end
         hrn_pkg::BS_DIV1: begin
            if (!div_busy) begin
               x_in     = (|div_q[79:64] || rad_sum[64]) ? {64{1'b1}} : rad_sum[63:0];
               root_in  = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = hrn_pkg::BS_ROOT;
            end
         end
         hrn_pkg::BS_ROOT: begin
            if ({1'b0, x_ff} >= trial) begin
               x_in    = x_ff - trial[63:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) state_in = hrn_pkg::BS_DIVS2;
         end
         hrn_pkg::BS_DIVS2: begin
            div_start    = 1'b1;
            div_dividend = hrn_pkg::DIVN_W'({1'b0, root_ff[31:0], 1'b0} + 34'(dt_ff));
            div_divisor  = {dt_ff, 1'b0};
            state_in     = hrn_pkg::BS_DIV2;
         end
         hrn_pkg::BS_DIV2: begin
            if (!div_busy) begin
               if (div_q < hrn_pkg::DIVN_W'(cfg.nt)) begin
                  idx_in   = NT_W'(div_q);
                  state_in = hrn_pkg::BS_PLACE;
               end else begin
                  state_in = hrn_pkg::BS_NEXT;
               end
            end
         end
         hrn_pkg::BS_PLACE: begin
            dst_in   = LW'(row_d) * LW'(cfg.nt) + LW'(col_d);
            src_in   = LW'(row_s) * LW'(cfg.nt) + LW'(col_s);
            state_in = hrn_pkg::BS_ACC_RD;
         end
         hrn_pkg::BS_ACC_RD: begin
            state_in = hrn_pkg::BS_ACC_WR;
         end
         hrn_pkg::BS_ACC_WR: begin
            res_we   = 1'b1;
            res_wd   = res_rd + {{8{src_rd[31]}}, src_rd};
            state_in = hrn_pkg::BS_NEXT;
         end
         hrn_pkg::BS_NEXT: begin
            state_in = hrn_pkg::BS_FETCH;
            if (iq_ff == cfg.nq - NTR_W'(1)) begin
               iq_in = '0;
               if (ih_ff == cfg.nh - NTR_W'(1)) begin
                  ih_in = '0;
                  if (it_ff == cfg.nt - NT_W'(1)) state_in = hrn_pkg::BS_DONE;
                  else it_in = it_ff + NT_W'(1);
               end else begin
                  ih_in = ih_ff + NTR_W'(1);
               end
            end else begin
               iq_in = iq_ff + NTR_W'(1);
            end
         end
         hrn_pkg::BS_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = 32'd0;
               rsp_status_in = hrn_pkg::STAT_OK;
               state_in      = hrn_pkg::BS_IDLE;
            end
         end
         default: begin
            state_in = hrn_pkg::BS_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   `HRN_ASSERT(a_acc_in_range, clock, reset, state_ff == hrn_pkg::BS_ACC_WR, idx_ff < cfg.nt)
   `HRN_ASSERT(a_div_idle, clock, reset, div_start, !div_busy)
   `HRN_ASSERT(a_pop_has_slot, clock, reset, q_pop, !rsp_valid_ff || rsp_chan.ready)
   `HRN_ASSERT_NEXT(a_root_ends, clock, reset, state_ff == hrn_pkg::BS_ROOT && bit_ff == 64'd1, state_ff == hrn_pkg::BS_DIVS2)

endmodule

@@ hw/rtl/hyperbolic_radon_nearest_core.sv @@
// Top level of the nearest-sample hyperbolic Radon core
// Requests enter on req_chan (opcode, index, load_value) under valid/ready;
// every request yields exactly one response on rsp_chan (read_value, status).
// csr_we/csr_index/csr_wdata write adjoint mode and the time, offset and curve
// counts; write them only while no request is outstanding.
// A front end checks each request against the active sizes and queues it in a
// two-entry queue; the back end owns the stores and runs the operator.
// Loads and rejected requests go through the queue and response register, one
// per cycle sustained while the receiver keeps up. A read holds the back end in
// IDLE and READ (registered result store read), so the next request waits for
// its answer. Run: a clearing pass over all MAX(MAX_OFFSETS,MAX_CURVES)*MAX_TIMES
// result entries, then per (time, offset, curve) sample two waits on the shared
// serial divider and the 32-step square root, with no accumulation where the
// index falls past the last time; a nonpositive slowness skips the sample, and
// a nonpositive time step ends the run after the clearing pass.
// Reset empties the queue, drops any pending response, restores the default
// sizes and makes reads return zero until the first run; the sample stores
// are not cleared. A stalled receiver holds the response; the back end then
// stops, and once the queue fills req_chan.ready falls.
module hyperbolic_radon_nearest_core #(
   parameter int MAX_TIMES   = 1024,
   parameter int MAX_OFFSETS = 64,
   parameter int MAX_CURVES  = 64
) (
   input  logic        clock,
   input  logic        reset,
   hrn_req_if.sink     req_chan,
   hrn_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   hrn_pkg::cfg_type cfg;
   hrn_pkg::cmd_type push_cmd, pop_cmd;
   logic             push, pop, full, empty;

   hrn_front #(
      .MAX_TIMES   (MAX_TIMES),
      .MAX_OFFSETS (MAX_OFFSETS),
      .MAX_CURVES  (MAX_CURVES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (full),
      .q_push    (push),
      .q_cmd     (push_cmd),
      .cfg       (cfg)
   );

   hrn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   hrn_back #(
      .MAX_TIMES   (MAX_TIMES),
      .MAX_OFFSETS (MAX_OFFSETS),
      .MAX_CURVES  (MAX_CURVES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_cmd    (pop_cmd),
      .q_empty  (empty),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
